>>> design/smv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smv_pkg
// types and constants for the sim access message validator
// ----------------------------------------------------------------------------
package smv_pkg;

    localparam int DEF_MESSAGE_HEADER_BYTES = 4;
    localparam int DEF_PARAM_HEADER_BYTES   = 4;

    localparam int TOTAL_W = 17;
    localparam int OFFS_W  = 16;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_HEADER = 2'd1,
        STATUS_OVERSIZE  = 2'd2,
        STATUS_MALFORMED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_MSG_HDR = 2'd0,
        PH_PAR_HDR = 2'd1,
        PH_BODY    = 2'd2,
        PH_TRAIL   = 2'd3
    } phase_t;

endpackage : smv_pkg
`default_nettype wire

>>> design/sap_message_validator.sv
`timescale 1ns / 1ps
`default_nettype none
// a last byte accepted on s_* goes through the input register, then the result register, to m_*
// one byte per cycle, bar the wait below; the state update is one counter/compare pass
// a last byte waits in the input register only while an earlier verdict is not taken
// reset: synchronous active-low aresetn clears walk state, limit register and valids
// ----------------------------------------------------------------------------
// sap_message_validator
// walks the bytes of one sim access message and gives a verdict on the last byte
// ----------------------------------------------------------------------------
module sap_message_validator
    import smv_pkg::*;
#(
    parameter int MESSAGE_HEADER_BYTES = DEF_MESSAGE_HEADER_BYTES,
    parameter int PARAM_HEADER_BYTES   = DEF_PARAM_HEADER_BYTES
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,  // max_message_size

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,      // [7:0] data_byte
    input  wire logic        s_tlast,      // last_byte

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata       // [1:0] status, [9:2] message_id,
                                           // [17:10] param_count, [25:18] params_complete
);

    localparam logic [TOTAL_W-1:0] MSG_HDR_LEN = TOTAL_W'(MESSAGE_HEADER_BYTES);
    localparam logic [TOTAL_W-1:0] PAR_HDR_LEN = TOTAL_W'(PARAM_HEADER_BYTES);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX   = {TOTAL_W{1'b1}};

    logic [15:0] max_size_reg;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    // walk state
    logic [TOTAL_W-1:0] total_reg,     total_next;
    phase_t             phase_reg,     phase_next;
    logic [OFFS_W-1:0]  offset_reg,    offset_next;
    logic [15:0]        vlen_reg,      vlen_next;
    logic [7:0]         declared_reg,  declared_next;
    logic [7:0]         completed_reg, completed_next;
    logic [7:0]         msg_id_reg,    msg_id_next;

    // result register
    logic        out_valid_reg;
    status_t     out_status_reg;
    logic [7:0]  out_id_reg;
    logic [7:0]  out_count_reg;
    logic [7:0]  out_done_reg;

    logic               out_free;
    logic               proc;
    logic [TOTAL_W-1:0] offset_inc;
    logic [TOTAL_W-1:0] padded;
    logic [7:0]         completed_inc;
    status_t            status_next;

    assign out_free = !out_valid_reg || m_tready;
    // non-last bytes never wait; a verdict needs a free result slot
    assign proc     = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || proc;

    assign offset_inc    = {1'b0, offset_reg} + TOTAL_W'(1);
    assign padded        = ({1'b0, vlen_reg} + TOTAL_W'(3)) & ~TOTAL_W'(3);
    assign completed_inc = completed_reg + 8'd1;

    always_comb begin
        total_next     = (total_reg < TOTAL_MAX) ? total_reg + TOTAL_W'(1) : total_reg;
        phase_next     = phase_reg;
        offset_next    = offset_reg;
        vlen_next      = vlen_reg;
        declared_next  = declared_reg;
        completed_next = completed_reg;
        msg_id_next    = msg_id_reg;

        unique case (phase_reg)
            PH_MSG_HDR: begin
                if (offset_reg == '0) begin
                    msg_id_next = in_byte_reg;
                end else if (offset_reg == OFFS_W'(1)) begin
                    declared_next = in_byte_reg;
                end
                offset_next = offset_inc[OFFS_W-1:0];
                if (offset_inc >= MSG_HDR_LEN) begin
                    offset_next = '0;
                    vlen_next   = '0;
                    phase_next  = (declared_next != 8'd0) ? PH_PAR_HDR : PH_TRAIL;
                end
            end
            PH_PAR_HDR: begin
                if (offset_reg == OFFS_W'(2) || offset_reg == OFFS_W'(3)) begin
                    vlen_next = {vlen_reg[7:0], in_byte_reg};
                end
                offset_next = offset_inc[OFFS_W-1:0];
                if (offset_inc >= PAR_HDR_LEN) begin
                    offset_next = '0;
                    if (vlen_next == 16'd0) begin
                        // empty value, parameter ends with its header
                        completed_next = completed_inc;
                        vlen_next      = '0;
                        phase_next     = (completed_inc == declared_reg) ? PH_TRAIL
                                                                         : PH_PAR_HDR;
                    end else begin
                        phase_next = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                offset_next = offset_inc[OFFS_W-1:0];
                if (offset_inc >= padded) begin
                    completed_next = completed_inc;
                    offset_next    = '0;
                    vlen_next      = '0;
                    phase_next     = (completed_inc == declared_reg) ? PH_TRAIL : PH_PAR_HDR;
                end
            end
            PH_TRAIL: begin
                // trailing bytes only count toward the total
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        priority if (total_next < MSG_HDR_LEN) begin
            status_next = STATUS_NO_HEADER;
        end else if (max_size_reg != 16'd0 && total_next > {1'b0, max_size_reg}) begin
            status_next = STATUS_OVERSIZE;
        end else if (completed_next != declared_next) begin
            status_next = STATUS_MALFORMED;
        end else begin
            status_next = STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_size_reg <= '0;
        end else if (cfg_wr_en) begin
            max_size_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg     <= '0;
            phase_reg     <= PH_MSG_HDR;
            offset_reg    <= '0;
            vlen_reg      <= '0;
            declared_reg  <= '0;
            completed_reg <= '0;
            msg_id_reg    <= '0;
        end else if (proc) begin
            if (in_last_reg) begin
                // verdict given, start clean for the next message
                total_reg     <= '0;
                phase_reg     <= PH_MSG_HDR;
                offset_reg    <= '0;
                vlen_reg      <= '0;
                declared_reg  <= '0;
                completed_reg <= '0;
                msg_id_reg    <= '0;
            end else begin
                total_reg     <= total_next;
                phase_reg     <= phase_next;
                offset_reg    <= offset_next;
                vlen_reg      <= vlen_next;
                declared_reg  <= declared_next;
                completed_reg <= completed_next;
                msg_id_reg    <= msg_id_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && in_last_reg) begin
            out_status_reg <= status_next;
            out_id_reg     <= msg_id_next;
            out_count_reg  <= declared_next;
            out_done_reg   <= (status_next == STATUS_NO_HEADER) ? 8'd0 : completed_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_done_reg, out_count_reg, out_id_reg, out_status_reg};

endmodule : sap_message_validator
`default_nettype wire

>>> bench/smv_verdict_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smv_verdict_checker
// follows the accepted message bytes, predicts each verdict and checks it
// against the result channel in order
// ----------------------------------------------------------------------------
module smv_verdict_checker
    import smv_pkg::*;
#(
    parameter int MSG_HDR = DEF_MESSAGE_HEADER_BYTES,
    parameter int PAR_HDR = DEF_PARAM_HEADER_BYTES
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,

    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        s_tlast,

    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,

    output int               errors,
    output int               pending
);

    typedef struct {
        status_t    status;
        logic [7:0] msg_id;
        logic [7:0] n_decl;
        logic [7:0] n_done;
    } verdict_t;

    verdict_t           verdict_q[$];

    logic [15:0]        size_limit;
    logic [TOTAL_W-1:0] total;
    phase_t             ph;
    logic [16:0]        offs;
    logic [15:0]        vlen;
    logic [7:0]         n_decl;
    logic [7:0]         n_done;
    logic [7:0]         msg_id;

    // value length rounded up to a multiple of four, needs 17 bits
    function automatic logic [16:0] pad4(input logic [15:0] len);
        logic [16:0] sum;
        sum = {1'b0, len} + 17'd3;
        return {sum[16:2], 2'b00};
    endfunction

    task automatic clear_walk();
        total  = '0;
        ph     = PH_MSG_HDR;
        offs   = '0;
        vlen   = '0;
        n_decl = '0;
        n_done = '0;
        msg_id = '0;
    endtask

    task automatic close_param();
        n_done = n_done + 8'd1;
        offs   = '0;
        vlen   = '0;
        ph     = (n_done == n_decl) ? PH_TRAIL : PH_PAR_HDR;
    endtask

    task automatic walk_byte(input logic [7:0] b, input logic last);
        verdict_t v;
        if (total != {TOTAL_W{1'b1}})
            total = total + 1'b1;

        case (ph)
            PH_MSG_HDR: begin
                if (offs == 0)
                    msg_id = b;
                else if (offs == 1)
                    n_decl = b;
                offs = offs + 1'b1;
                if (offs >= MSG_HDR) begin
                    offs = '0;
                    vlen = '0;
                    ph   = (n_decl != 0) ? PH_PAR_HDR : PH_TRAIL;
                end
            end
            PH_PAR_HDR: begin
                // length is big-endian in the last two header bytes
                if (offs == 2 || offs == 3)
                    vlen = {vlen[7:0], b};
                offs = offs + 1'b1;
                if (offs >= PAR_HDR) begin
                    offs = '0;
                    if (pad4(vlen) == 0)
                        close_param();
                    else
                        ph = PH_BODY;
                end
            end
            PH_BODY: begin
                offs = offs + 1'b1;
                if (offs >= pad4(vlen))
                    close_param();
            end
            default: ;
        endcase

        if (last) begin
            if (total < MSG_HDR)
                v.status = STATUS_NO_HEADER;
            else if (size_limit != 0 && total > size_limit)
                v.status = STATUS_OVERSIZE;
            else if (n_done != n_decl)
                v.status = STATUS_MALFORMED;
            else
                v.status = STATUS_OK;
            v.msg_id = msg_id;
            v.n_decl = n_decl;
            v.n_done = n_done;
            verdict_q.push_back(v);
            clear_walk();
        end
    endtask

    task automatic check_result(input logic [31:0] data);
        verdict_t want;
        if (verdict_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("%0t: result %h with no verdict pending", $realtime, data);
        end else begin
            want = verdict_q.pop_front();
            if (data[1:0] !== want.status || data[9:2] !== want.msg_id ||
                data[17:10] !== want.n_decl || data[25:18] !== want.n_done ||
                data[31:26] !== 6'd0) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0t: verdict mismatch: expected status %0d id %h count %0d done %0d",
                             $realtime, want.status, want.msg_id, want.n_decl, want.n_done);
                    $display("%0t: got status %0d id %h count %0d done %0d pad %h",
                             $realtime, data[1:0], data[9:2], data[17:10],
                             data[25:18], data[31:26]);
                end
            end
        end
    endtask

    initial begin
        errors  = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            size_limit = '0;
            clear_walk();
            verdict_q.delete();
        end else begin
            if (cfg_wr_en)
                size_limit = cfg_wr_data;
            // byte first: a verdict can never leave in the cycle its byte arrives
            if (s_tvalid && s_tready)
                walk_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                check_result(m_tdata);
        end
        pending = verdict_q.size();
    end

endmodule

>>> bench/sap_message_validator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sap_message_validator_tb
// streams directed and random sim access messages into the validator under
// changing size limits and random backpressure; a side checker predicts and
// compares every verdict
// ----------------------------------------------------------------------------
module sap_message_validator_tb;
    import smv_pkg::*;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = '0;     // [7:0] data_byte
    logic        s_tlast     = 1'b0;   // last_byte
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [31:0] m_tdata;              // [1:0] status, [9:2] message_id,
                                       // [17:10] param_count, [25:18] params_complete

    int          errors;
    int          pending;
    int unsigned sent;
    bit          gaps_on;
    bit          hold_req;
    logic [7:0]  msg_bytes[$];

    sap_message_validator dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    smv_verdict_checker verdict_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .errors      (errors),
        .pending     (pending)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("sap_message_validator_tb: errors");
        $finish;
    end

    // result side: random stalls, free-running stretches, one long hold on request
    initial begin
        int unsigned hold_left;
        int unsigned idle_left;
        int unsigned mode_left;
        bit          free_run;
        hold_left = 0;
        idle_left = 0;
        mode_left = 0;
        free_run  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 299;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    free_run  = ($urandom_range(0, 3) == 0);
                    mode_left = $urandom_range(50, 300);
                end
                mode_left--;
                if (free_run) begin
                    m_tready <= 1'b1;
                end else if (idle_left > 0) begin
                    idle_left--;
                    m_tready <= 1'b0;
                end else if ($urandom_range(0, 2) == 0) begin
                    idle_left = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                             : $urandom_range(0, 2);
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    task automatic drive_byte(input logic [7:0] d, input logic l);
        int unsigned gap;
        gap = 0;
        if (gaps_on && $urandom_range(0, 3) == 0)
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= l;
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic flush_msg();
        int unsigned i;
        for (i = 0; i < msg_bytes.size(); i++)
            drive_byte(msg_bytes[i], i == msg_bytes.size() - 1);
        msg_bytes.delete();
    endtask

    task automatic push_header(input logic [7:0] id, input logic [7:0] count);
        msg_bytes.push_back(id);
        msg_bytes.push_back(count);
        msg_bytes.push_back(8'($urandom));
        msg_bytes.push_back(8'($urandom));
    endtask

    task automatic push_param(input logic [15:0] len);
        int unsigned padded;
        padded = (32'(len) + 3) / 4 * 4;
        msg_bytes.push_back(8'($urandom));
        msg_bytes.push_back(8'($urandom));
        msg_bytes.push_back(len[15:8]);
        msg_bytes.push_back(len[7:0]);
        repeat (padded) msg_bytes.push_back(8'($urandom));
    endtask

    // mostly well-formed messages, some cut short, some plain noise
    task automatic random_msg();
        int unsigned kind;
        int unsigned cnt;
        int unsigned cut;
        kind = $urandom_range(0, 9);
        if (kind < 8) begin
            cnt = $urandom_range(0, 3);
            push_header(8'($urandom), 8'(cnt));
            repeat (cnt)
                push_param(16'(($urandom_range(0, 19) == 0) ? $urandom_range(256, 280)
                                                            : $urandom_range(0, 9)));
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) msg_bytes.push_back(8'($urandom));
            if (kind >= 6 && msg_bytes.size() > 1) begin
                cut = $urandom_range(1, msg_bytes.size() - 1);
                while (msg_bytes.size() > cut)
                    void'(msg_bytes.pop_back());
            end
        end else begin
            repeat ($urandom_range(1, 12)) msg_bytes.push_back(8'($urandom));
        end
        flush_msg();
    endtask

    task automatic run_random(input int unsigned n);
        int unsigned target;
        target = sent + n;
        while (sent < target)
            random_msg();
    endtask

    // stop offering and wait out every verdict plus the pipeline
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_limit(input logic [15:0] v);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        sent     = 0;
        gaps_on  = 1'b1;
        hold_req = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // header missing: one byte, then id and count but no full header
        msg_bytes = '{8'hFF};
        flush_msg();
        msg_bytes = '{8'h00, 8'hFF, 8'h5A};
        flush_msg();
        // header only, no parameters declared
        push_header(8'h80, 8'h00);
        flush_msg();
        // empty value
        push_header(8'h01, 8'h01);
        push_param(16'h0000);
        flush_msg();
        // length already a multiple of four, no padding
        push_header(8'h7F, 8'h01);
        push_param(16'h0004);
        flush_msg();

        settle();
        set_limit(16'hFFFF);
        run_random(300);

        settle();
        set_limit(16'd1);
        run_random(200);

        settle();
        set_limit(16'($urandom_range(8, 40)));
        run_random(150);
        // receiver holds off while single-byte messages pile up
        hold_req = 1'b1;
        repeat (30) begin
            msg_bytes.push_back(8'($urandom));
            flush_msg();
        end
        run_random(150);

        settle();
        set_limit(16'd0);
        gaps_on = 1'b0;
        run_random(400);
        gaps_on = 1'b1;

        settle();
        set_limit(16'($urandom_range(20, 60)));
        run_random(300);

        settle();
        set_limit(16'($urandom_range(1024, 65535)));
        run_random(300);

        settle();
        set_limit(16'hFFFF);
        run_random(50);

        settle();
        repeat (4) @(posedge aclk);
        if (errors == 0)
            $display("sap_message_validator_tb: clean");
        else
            $display("sap_message_validator_tb: errors");
        $finish;
    end

endmodule

>>> files.f
design/smv_pkg.sv
design/sap_message_validator.sv
bench/smv_verdict_checker.sv
bench/sap_message_validator_tb.sv
